/* sv/sensor_readout_segment_display_macros.svh */
// assertion macros for the sensor readout display block
`ifndef SENSOR_READOUT_SEGMENT_DISPLAY_MACROS_SVH
`define SENSOR_READOUT_SEGMENT_DISPLAY_MACROS_SVH
`ifndef SYNTH
`define SRSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srsd same-cycle check failed");
`define SRSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srsd next-cycle check failed");
`else
`define SRSD_ASSERT_NOW(lbl, ante, cons)
`define SRSD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/srsd_pkg.sv */
// shared types, constants and segment decode for the sensor readout display
`timescale 1ns / 1ps
package srsd_pkg;

  localparam int TimerW   = 16;
  localparam int TempW    = 11;
  localparam int HumW     = 10;
  localparam int ElapsedW = 8;
  localparam int OffW     = 5;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int FbW      = 13;
  localparam int HrW      = 7;
  localparam int SegW     = 8;

  localparam logic [TimerW-1:0] TIMER_MAX = '1;

  localparam logic [TimerW-1:0] SAMPLE_PERIOD_RST = 16'd6000;
  localparam logic [TimerW-1:0] SHOW_TEMP_RST     = 16'd3000;
  localparam logic [TimerW-1:0] STARTUP_DELAY_RST = 16'd2000;
  localparam logic [OffW-1:0]   TEMP_OFF_RST      = 5'h1F;
  localparam logic [OffW-1:0]   HUM_OFF_RST       = 5'h00;

  localparam logic [FbW-1:0] F_ZERO_TENTHS = 13'd320;
  localparam logic [FbW-1:0] TEMP_HIGH     = 13'd1000;

  localparam logic [SegW-1:0] SEG_BLANK   = 8'hFF;
  localparam logic [SegW-1:0] SEG_DP_MASK = 8'h7F;
  localparam logic [SegW-1:0] SEG_H       = 8'h89;
  localparam logic [SegW-1:0] SEG_E       = 8'h86;
  localparam logic [SegW-1:0] SEG_MINUS   = 8'hBF;
  localparam logic [SegW-1:0] SEG_R       = 8'hAF;
  localparam logic [SegW-1:0] SEG_D       = 8'hA1;
  localparam logic [SegW-1:0] SEG_Y       = 8'h91;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAMPLE_PERIOD = 3'd0,
    CFG_SHOW_TEMP     = 3'd1,
    CFG_STARTUP_DELAY = 3'd2,
    CFG_TEMP_OFFSET   = 3'd3,
    CFG_HUM_OFFSET    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [TimerW-1:0] period_ms;
    logic [TimerW-1:0] temp_show_ms;
    logic [TimerW-1:0] warmup_ms;
    logic [OffW-1:0]   temp_adj;
    logic [OffW-1:0]   hum_adj;
  } cfg_t;

  typedef struct packed {
    logic                action;
    logic [ElapsedW-1:0] elapsed_ms;
    logic                reading_ok;
    logic [TempW-1:0]    temp_dc;
    logic [HumW-1:0]     rh_tenths;
  } item_t;

  // temperature kept as fahrenheit tenths before offset, humidity as whole percent
  typedef struct packed {
    logic [TimerW-1:0] startup_timer;
    logic [TimerW-1:0] since_sample_timer;
    logic [TimerW-1:0] cycle_timer;
    logic [FbW-1:0]    temp_f_base;
    logic [HrW-1:0]    hum_round;
    logic              has_data;
    logic              read_failed;
  } view_t;

  typedef struct packed {
    logic [SegW-1:0] left;
    logic [SegW-1:0] middle;
    logic [SegW-1:0] right;
    logic            sample_due;
  } disp_t;

  function automatic logic [SegW-1:0] seg_digit(input logic [3:0] d);
    logic [SegW-1:0] s;
    unique case (d)
      4'd0: s = 8'hC0;
      4'd1: s = 8'hF9;
      4'd2: s = 8'hA4;
      4'd3: s = 8'hB0;
      4'd4: s = 8'h99;
      4'd5: s = 8'h92;
      4'd6: s = 8'h82;
      4'd7: s = 8'hF8;
      4'd8: s = 8'h80;
      4'd9: s = 8'h90;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

/* sv/srsd_cfg.sv */
// configuration register file
`timescale 1ns / 1ps
module srsd_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srsd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [srsd_pkg::CfgDataW-1:0] cfg_data,
  output srsd_pkg::cfg_t                cfg
);
  import srsd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SAMPLE_PERIOD: cfg_nxt.period_ms    = cfg_data[TimerW-1:0];
        CFG_SHOW_TEMP:     cfg_nxt.temp_show_ms = cfg_data[TimerW-1:0];
        CFG_STARTUP_DELAY: cfg_nxt.warmup_ms    = cfg_data[TimerW-1:0];
        CFG_TEMP_OFFSET:   cfg_nxt.temp_adj     = cfg_data[OffW-1:0];
        CFG_HUM_OFFSET:    cfg_nxt.hum_adj      = cfg_data[OffW-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_ms    <= SAMPLE_PERIOD_RST;
      cfg_r.temp_show_ms <= SHOW_TEMP_RST;
      cfg_r.warmup_ms    <= STARTUP_DELAY_RST;
      cfg_r.temp_adj     <= TEMP_OFF_RST;
      cfg_r.hum_adj      <= HUM_OFF_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* sv/srsd_state.sv */
// timers, stored reading and status flags, updated once per item
`timescale 1ns / 1ps
module srsd_state (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            upd_en,
  input  srsd_pkg::item_t item,
  input  srsd_pkg::cfg_t  cfg,
  output srsd_pkg::view_t view
);
  import srsd_pkg::*;

  logic [TimerW-1:0] startup_r, startup_nxt;
  logic [TimerW-1:0] since_r, since_nxt;
  logic [TimerW-1:0] cycle_r, cycle_nxt;
  logic [FbW-1:0]    fbase_r, fbase_nxt;
  logic [HrW-1:0]    hround_r, hround_nxt;
  logic              have_r, have_nxt;
  logic              failed_r, failed_nxt;

  logic [TimerW:0]   startup_sum;
  logic [TimerW:0]   since_sum;
  logic [TimerW:0]   cycle_sum;
  logic [TimerW-1:0] cycle_sat;

  logic [14:0]       t_ext;
  logic [14:0]       t_lin;
  logic [13:0]       t_mag;
  logic [29:0]       t_prod;
  logic [FbW-1:0]    t_quot;

  logic [HumW:0]     h_bias;
  logic [18:0]       h_prod;

  assign view = '{startup_timer:      startup_r,
                  since_sample_timer: since_r,
                  cycle_timer:        cycle_r,
                  temp_f_base:        fbase_r,
                  hum_round:          hround_r,
                  has_data:           have_r,
                  read_failed:        failed_r};

  // timer adds with saturation
  always_comb begin
    startup_sum = {1'b0, startup_r} + {{(TimerW + 1 - ElapsedW){1'b0}}, item.elapsed_ms};
    since_sum   = {1'b0, since_r}   + {{(TimerW + 1 - ElapsedW){1'b0}}, item.elapsed_ms};
    cycle_sum   = {1'b0, cycle_r}   + {{(TimerW + 1 - ElapsedW){1'b0}}, item.elapsed_ms};
    cycle_sat   = cycle_sum[TimerW] ? TIMER_MAX : cycle_sum[TimerW-1:0];
  end

  // celsius tenths to fahrenheit tenths, /5 by reciprocal on the magnitude
  always_comb begin
    t_ext  = {{(15 - TempW){item.temp_dc[TempW-1]}}, item.temp_dc};
    t_lin  = 15'((t_ext << 3) + t_ext + 15'd25);
    t_mag  = t_lin[14] ? 14'(15'd0 - t_lin) : t_lin[13:0];
    t_prod = {16'd0, t_mag} * 30'd52429;
    t_quot = {2'b00, t_prod[28:18]};
    fbase_nxt = 13'((t_lin[14] ? (13'd0 - t_quot) : t_quot) + F_ZERO_TENTHS);
  end

  // humidity rounded to whole percent
  always_comb begin
    h_bias     = {1'b0, item.rh_tenths} + 11'd5;
    h_prod     = {8'd0, h_bias} * 19'd205;
    hround_nxt = h_prod[17:11];
  end

  always_comb begin
    startup_nxt = startup_r;
    since_nxt   = since_r;
    cycle_nxt   = cycle_r;
    have_nxt    = have_r;
    failed_nxt  = failed_r;
    if (!item.action) begin
      if (item.elapsed_ms != '0) begin
        if (startup_r < cfg.warmup_ms) begin
          startup_nxt = startup_sum[TimerW] ? TIMER_MAX : startup_sum[TimerW-1:0];
        end
        since_nxt = since_sum[TimerW] ? TIMER_MAX : since_sum[TimerW-1:0];
        cycle_nxt = (cycle_sat >= cfg.period_ms) ? '0 : cycle_sat;
      end
    end else begin
      if (item.reading_ok) begin
        have_nxt   = 1'b1;
        failed_nxt = 1'b0;
      end else begin
        failed_nxt = 1'b1;
      end
      since_nxt = '0;
      cycle_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      startup_r <= '0;
      since_r   <= '0;
      cycle_r   <= '0;
      have_r    <= 1'b0;
      failed_r  <= 1'b0;
    end else if (upd_en) begin
      startup_r <= startup_nxt;
      since_r   <= since_nxt;
      cycle_r   <= cycle_nxt;
      have_r    <= have_nxt;
      failed_r  <= failed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en && item.action && item.reading_ok) begin
      fbase_r  <= fbase_nxt;
      hround_r <= hround_nxt;
    end
  end

endmodule

/* sv/srsd_fmt.sv */
// display formatting: temperature, humidity and status words to segment bytes
`timescale 1ns / 1ps
module srsd_fmt (
  input  srsd_pkg::cfg_t  cfg,
  input  srsd_pkg::view_t view,
  output srsd_pkg::disp_t disp
);
  import srsd_pkg::*;

  logic [FbW-1:0]  off_ext;
  logic [FbW-1:0]  f;
  logic            f_neg;
  logic            f_high;
  logic [11:0]     w;
  logic [27:0]     p1;
  logic [7:0]      q1;
  logic [15:0]     p2;
  logic [4:0]      q2;
  logic [7:0]      q2x10;
  logic [11:0]     q1x10;
  logic [3:0]      d1;
  logic [3:0]      d0;
  logic [1:0]      hh;
  logic [3:0]      hm;

  logic [8:0]      h_sum;
  logic [6:0]      h_clamp;
  logic [14:0]     h_prod;
  logic [3:0]      h_tens;
  logic [3:0]      h_ones;

  logic [SegW-1:0] t_left, t_mid, t_right;

  // fahrenheit tenths with offset, then one shared digit split
  always_comb begin
    off_ext = {{(FbW - OffW){cfg.temp_adj[OffW-1]}}, cfg.temp_adj};
    f       = 13'(view.temp_f_base + (off_ext << 3) + (off_ext << 1));
    f_neg   = f[FbW-1];
    f_high  = !f_neg && (f >= TEMP_HIGH);
    if (f_neg) begin
      w = 12'(13'd0 - f);
    end else if (f_high) begin
      w = 12'(f + 13'd5);
    end else begin
      w = f[11:0];
    end
    p1    = {16'd0, w} * 28'd52429;
    q1    = p1[26:19];
    p2    = {8'd0, q1} * 16'd205;
    q2    = p2[15:11];
    q2x10 = {3'b000, q2} * 8'd10;
    q1x10 = {4'd0, q1} * 12'd10;
    d1    = 4'(q1 - q2x10);
    d0    = 4'(w - q1x10);
    if (q2 >= 5'd20) begin
      hh = 2'd2;
    end else if (q2 >= 5'd10) begin
      hh = 2'd1;
    end else begin
      hh = 2'd0;
    end
    hm = 4'(q2 - 5'({3'b000, hh} * 5'd10));
  end

  always_comb begin
    priority if (f_neg) begin
      t_left  = SEG_MINUS;
      t_mid   = seg_digit(d1);
      t_right = seg_digit(d0);
    end else if (f_high) begin
      t_left  = seg_digit({2'b00, hh});
      t_mid   = seg_digit(hm);
      t_right = seg_digit(d1);
    end else begin
      t_left  = (q2 == '0) ? SEG_BLANK : seg_digit(q2[3:0]);
      t_mid   = seg_digit(d1) & SEG_DP_MASK;
      t_right = seg_digit(d0);
    end
  end

  // humidity with offset, clamped to two digits
  always_comb begin
    h_sum = {2'b00, view.hum_round} + {{(9 - OffW){cfg.hum_adj[OffW-1]}},
                                       cfg.hum_adj};
    if (h_sum[8]) begin
      h_clamp = '0;
    end else if (h_sum[7:0] > 8'd99) begin
      h_clamp = 7'd99;
    end else begin
      h_clamp = h_sum[6:0];
    end
    h_prod = {8'd0, h_clamp} * 15'd205;
    h_tens = h_prod[14:11];
    h_ones = 4'(h_clamp - 7'({3'b000, h_tens} * 7'd10));
  end

  always_comb begin
    disp.sample_due = (view.startup_timer >= cfg.warmup_ms) &&
                      (view.since_sample_timer >= cfg.period_ms);
    priority if (view.read_failed) begin
      disp.left   = SEG_E;
      disp.middle = SEG_R;
      disp.right  = SEG_R;
    end else if (view.has_data) begin
      if (view.cycle_timer < cfg.temp_show_ms) begin
        disp.left   = t_left;
        disp.middle = t_mid;
        disp.right  = t_right;
      end else begin
        disp.left   = SEG_H;
        disp.middle = seg_digit(h_tens);
        disp.right  = seg_digit(h_ones);
      end
    end else begin
      disp.left   = SEG_R;
      disp.middle = SEG_D;
      disp.right  = SEG_Y;
    end
  end

endmodule

/* sv/sensor_readout_segment_display.sv */
// top level: input register, state update and display formatting pipeline
`timescale 1ns / 1ps
`include "sensor_readout_segment_display_macros.svh"
// Takes one item per clock while in_stall is low (a millisecond tick or a sensor
// reading) and returns one result per item: three active-low segment bytes and the
// sample-due flag. An item passes the input register, then updates the timers and
// stored reading, and is then formatted into the output register; an output stall
// can hold it between these steps. Each stage holds one item, which sets the
// sustained rate at one item per cycle while out_stall is low; a stalled result
// holds the output register while up to two more items wait in the earlier stages.
// There is no clearing pass after reset, and configuration writes are never stalled.
module sensor_readout_segment_display (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [srsd_pkg::ElapsedW-1:0] in_elapsed_ms,
  input  logic                          in_reading_ok,
  input  logic signed [srsd_pkg::TempW-1:0] in_temp_dc,
  input  logic [srsd_pkg::HumW-1:0]     in_rh_tenths,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [srsd_pkg::SegW-1:0]     out_segment_left,
  output logic [srsd_pkg::SegW-1:0]     out_segment_middle,
  output logic [srsd_pkg::SegW-1:0]     out_segment_right,
  output logic                          out_sample_due,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srsd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [srsd_pkg::CfgDataW-1:0] cfg_data
);
  import srsd_pkg::*;

  cfg_t  cfg;
  view_t view;
  disp_t disp;

  item_t item_r;
  logic  s1_v_r, s1_v_nxt;
  logic  pend_r, pend_nxt;
  logic  out_valid_r, out_valid_nxt;
  disp_t disp_r;

  logic  fmt_go;
  logic  upd_go;
  logic  in_take;

  srsd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  srsd_state u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (upd_go),
    .item   (item_r),
    .cfg    (cfg),
    .view   (view)
  );

  srsd_fmt u_fmt (
    .cfg  (cfg),
    .view (view),
    .disp (disp)
  );

  // pend_r: state holds an update whose result is not yet in the output register
  always_comb begin
    fmt_go   = pend_r && (!out_valid_r || !out_stall);
    upd_go   = s1_v_r && (!pend_r || fmt_go);
    in_stall = s1_v_r && !upd_go;
    in_take  = in_valid && !in_stall;

    s1_v_nxt = in_take || (s1_v_r && !upd_go);

    if (upd_go) begin
      pend_nxt = 1'b1;
    end else if (fmt_go) begin
      pend_nxt = 1'b0;
    end else begin
      pend_nxt = pend_r;
    end

    if (fmt_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= '{action:     in_action,
                  elapsed_ms: in_elapsed_ms,
                  reading_ok: in_reading_ok,
                  temp_dc:    in_temp_dc,
                  rh_tenths:  in_rh_tenths};
    end
    if (fmt_go) begin
      disp_r <= disp;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_segment_left   = disp_r.left;
  assign out_segment_middle = disp_r.middle;
  assign out_segment_right  = disp_r.right;
  assign out_sample_due     = disp_r.sample_due;

  `SRSD_ASSERT_NEXT(a_upd_sets_pend, upd_go, pend_r)
  `SRSD_ASSERT_NOW(a_no_state_overwrite, upd_go && pend_r, fmt_go)
  `SRSD_ASSERT_NEXT(a_fmt_loads_out, fmt_go, out_valid_r)
  `SRSD_ASSERT_NOW(a_stall_only_when_full, in_stall, s1_v_r && pend_r && out_valid_r)

endmodule
